// File: hdl/cheb_pkg.sv
// Package with shared constants, types and the pipeline stage record of the Chebyshev evaluator.
`timescale 1ns / 1ps
`default_nettype none
package cheb_pkg;

   localparam int MAX_ORDER  = 7;
   localparam int NUM_COEF   = 8;
   localparam int NUM_CELLS  = MAX_ORDER + 1;
   localparam int COEF_IDX_W = $clog2(NUM_COEF);
   localparam int CSR_IDX_W  = 8;

   localparam int COEF_W     = 24;
   localparam int X_W        = 16;
   localparam int T_W        = 16;
   localparam int W1_W       = 30;
   localparam int W2_W       = 34;
   localparam int ACC_W      = 56;
   localparam int OUT_W      = 48;
   localparam int FRAC_SHIFT = 14;
   localparam int ONE_Q14    = 16384;
   localparam int ROUND_BIAS = 8192;

   typedef logic signed [COEF_W-1:0] coef_type;
   typedef logic signed [X_W-1:0]    x_type;
   typedef logic signed [T_W-1:0]    t_type;
   typedef logic signed [W1_W-1:0]   w1_type;
   typedef logic signed [W2_W-1:0]   w2_type;
   typedef logic signed [ACC_W-1:0]  acc_type;
   typedef logic signed [OUT_W-1:0]  out_type;

   // One item as it moves down the row of cells.
   typedef struct packed {
      logic    valid;
      logic    err;
      x_type   x;
      t_type   t1;   // newest polynomial value
      t_type   t2;   // the one before it, which the cell accumulates
      acc_type val;
      acc_type d1;
      acc_type d2;
   } stage_type;

endpackage
`default_nettype wire

// File: hdl/chebyshev_series_eval_derivs.sv
// Top level of the Chebyshev series evaluator with first and second derivatives.
//
// Usage: coefficients c0..c7 (signed, 16 fraction bits) are written on the
// csr_ channel, one register per write; csr_ready is always high and an index
// above seven is dropped. Points x (signed Q1.14) enter on req_, and for each
// item one result leaves on rsp_ holding f(x), f'(x) and f''(x) with 16
// fraction bits, saturated to 48 bits, plus a range flag in tuser. A point
// outside [-1,1] sets the flag and zeroes the three values.
// Pipeline: the input register takes the item at the accepting edge, then
// one cell per polynomial order follows (eight cells, each doing a recurrence
// step and one term of the three sums) and finally the output register.
// Throughput is one item per clock while the receiver keeps taking results,
// set by the row of cells, each of which holds one item.
// When the receiver stalls, items pile up behind the output register; empty
// stages keep filling, so req_tready drops only when every stage is full.
// Reset clears all coefficients to zero and empties the pipeline. A
// coefficient write takes effect for items accepted on the following cycle.
`timescale 1ns / 1ps
`default_nettype none
module chebyshev_series_eval_derivs (
   input  wire logic         clock,
   input  wire logic         reset,
   // Input items.
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [15:0]  req_tdata,    // [15:0] x_point
   // Result items.
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [143:0]      rsp_tdata,    // [47:0] series_value, [95:48] first_derivative,
                                           // [143:96] second_derivative
   output logic              rsp_tuser,    // [0] range_error
   // Coefficient writes.
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic [7:0]   csr_index,
   input  wire logic [23:0]  csr_data
);

   localparam int NC = cheb_pkg::NUM_CELLS;

   cheb_pkg::coef_type   coef_ff [cheb_pkg::NUM_COEF];
   cheb_pkg::w1_type     w1 [NC];
   cheb_pkg::w2_type     w2 [NC];
   cheb_pkg::stage_type  stage_bus [NC+1];
   cheb_pkg::stage_type  head_ff, head_in;
   logic                 en [NC+1];
   logic                 out_ready;
   cheb_pkg::x_type      x_in;

   // Coefficient registers.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < cheb_pkg::NUM_COEF; i++) begin
            coef_ff[i] <= '0;
         end
      end else if (csr_valid && (csr_index < cheb_pkg::CSR_IDX_W'(cheb_pkg::NUM_COEF))) begin
         coef_ff[csr_index[cheb_pkg::COEF_IDX_W-1:0]] <= cheb_pkg::coef_type'(csr_data);
      end
   end

   cheb_weights u_weights (
      .clock (clock),
      .reset (reset),
      .coef  (coef_ff),
      .w1    (w1),
      .w2    (w2)
   );

   // A stage loads when it is empty or when its item moves on, so bubbles
   // close up even while the output is held.
   always_comb begin
      en[NC] = !stage_bus[NC].valid || out_ready;
      for (int i = NC - 1; i >= 0; i--) begin
         en[i] = !stage_bus[i].valid || en[i+1];
      end
   end

   assign req_tready = en[0];

   // Input register: T1 = x, T0 = one, sums empty.
   always_comb begin
      x_in          = cheb_pkg::x_type'(req_tdata);
      head_in.valid = req_tvalid;
      head_in.err   = (x_in < -cheb_pkg::X_W'(cheb_pkg::ONE_Q14))
                   || (x_in >  cheb_pkg::X_W'(cheb_pkg::ONE_Q14));
      head_in.x     = x_in;
      head_in.t1    = x_in;
      head_in.t2    = cheb_pkg::T_W'(cheb_pkg::ONE_Q14);
      head_in.val   = '0;
      head_in.d1    = '0;
      head_in.d2    = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff.valid <= 1'b0;
      end else if (en[0]) begin
         head_ff <= head_in;
      end
   end

   assign stage_bus[0] = head_ff;

   // Cell k adds the terms of T_k while computing T_(k+2).
   for (genvar k = 0; k < NC; k++) begin : g_cell
      cheb_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .enable    (en[k+1]),
         .stage_in  (stage_bus[k]),
         .coef      (coef_ff[k]),
         .w1        (w1[k]),
         .w2        (w2[k]),
         .stage_out (stage_bus[k+1])
      );
   end

   cheb_out u_out (
      .clock      (clock),
      .reset      (reset),
      .stage_in   (stage_bus[NC]),
      .ready      (out_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
`default_nettype wire

// File: hdl/cheb_weights.sv
// Registered derivative weights formed from the coefficient registers.
`timescale 1ns / 1ps
`default_nettype none
module cheb_weights (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire cheb_pkg::coef_type coef [cheb_pkg::NUM_COEF],
   output cheb_pkg::w1_type      w1   [cheb_pkg::NUM_CELLS],
   output cheb_pkg::w2_type      w2   [cheb_pkg::NUM_CELLS]
);

   cheb_pkg::w1_type w1_in [cheb_pkg::NUM_CELLS];
   cheb_pkg::w2_type w2_in [cheb_pkg::NUM_CELLS];
   cheb_pkg::w1_type w1_ff [cheb_pkg::NUM_CELLS];
   cheb_pkg::w2_type w2_ff [cheb_pkg::NUM_CELLS];

   // Index zero carries the constant terms, which meet T0 in the first cell.
   // All factors are constants, so each sum is a few shifted adds.
   always_comb begin
      for (int n = 0; n < cheb_pkg::NUM_CELLS; n++) begin
         w1_in[n] = '0;
         w2_in[n] = '0;
         for (int k = 1; k <= cheb_pkg::MAX_ORDER; k++) begin
            if (n == 0) begin
               if ((k % 2) == 1) begin
                  w1_in[n] = w1_in[n] + cheb_pkg::W1_W'(k) * cheb_pkg::W1_W'(coef[k]);
               end else begin
                  w2_in[n] = w2_in[n]
                           + cheb_pkg::W2_W'((k * k * k) / 2) * cheb_pkg::W2_W'(coef[k]);
               end
            end else begin
               if ((k > n) && (((k - n) % 2) == 1)) begin
                  w1_in[n] = w1_in[n]
                           + cheb_pkg::W1_W'(2 * k) * cheb_pkg::W1_W'(coef[k]);
               end
               if ((k > n + 1) && (((k - n) % 2) == 0)) begin
                  w2_in[n] = w2_in[n]
                           + cheb_pkg::W2_W'(k * (k * k - n * n)) * cheb_pkg::W2_W'(coef[k]);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int n = 0; n < cheb_pkg::NUM_CELLS; n++) begin
         if (reset) begin
            w1_ff[n] <= '0;
            w2_ff[n] <= '0;
         end else begin
            w1_ff[n] <= w1_in[n];
            w2_ff[n] <= w2_in[n];
         end
      end
   end

   assign w1 = w1_ff;
   assign w2 = w2_ff;

endmodule
`default_nettype wire

// File: hdl/cheb_cell.sv
// One cell of the row: next recurrence step plus accumulation of one polynomial term.
`timescale 1ns / 1ps
`default_nettype none
module cheb_cell (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 enable,
   input  wire cheb_pkg::stage_type  stage_in,
   input  wire cheb_pkg::coef_type   coef,
   input  wire cheb_pkg::w1_type     w1,
   input  wire cheb_pkg::w2_type     w2,
   output cheb_pkg::stage_type       stage_out
);

   localparam int PROD_W = 2 * cheb_pkg::T_W;
   localparam int DIFF_W = PROD_W + 2;

   logic signed [PROD_W-1:0]                 prod;
   logic signed [PROD_W:0]                   twice;
   logic signed [PROD_W:0]                   rnd;
   logic signed [DIFF_W-1:0]                 diff;
   cheb_pkg::t_type                          t_new;
   logic signed [cheb_pkg::COEF_W+cheb_pkg::T_W-1:0] pv;
   logic signed [cheb_pkg::W1_W+cheb_pkg::T_W-1:0]   p1;
   logic signed [cheb_pkg::W2_W+cheb_pkg::T_W-1:0]   p2;
   cheb_pkg::stage_type                      stage_in_next;
   cheb_pkg::stage_type                      stage_ff;

   // T_n = round(2 x T_(n-1)) - T_(n-2), clamped to plus or minus one.
   always_comb begin
      prod  = stage_in.x * stage_in.t1;
      twice = signed'({prod, 1'b0});
      rnd   = (twice + (PROD_W + 1)'(cheb_pkg::ROUND_BIAS)) >>> cheb_pkg::FRAC_SHIFT;
      diff  = DIFF_W'(rnd) - DIFF_W'(stage_in.t2);
      priority if (diff > DIFF_W'(cheb_pkg::ONE_Q14)) begin
         t_new = cheb_pkg::T_W'(cheb_pkg::ONE_Q14);
      end else if (diff < -DIFF_W'(cheb_pkg::ONE_Q14)) begin
         t_new = -cheb_pkg::T_W'(cheb_pkg::ONE_Q14);
      end else begin
         t_new = cheb_pkg::T_W'(diff);
      end
   end

   // The older polynomial value is already registered, so its products
   // start straight from a flip-flop.
   always_comb begin
      pv = coef * stage_in.t2;
      p1 = w1 * stage_in.t2;
      p2 = w2 * stage_in.t2;
      stage_in_next       = stage_in;
      stage_in_next.t1    = t_new;
      stage_in_next.t2    = stage_in.t1;
      stage_in_next.val   = stage_in.val + cheb_pkg::ACC_W'(pv);
      stage_in_next.d1    = stage_in.d1  + cheb_pkg::ACC_W'(p1);
      stage_in_next.d2    = stage_in.d2  + cheb_pkg::ACC_W'(p2);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else if (enable) begin
         stage_ff <= stage_in_next;
      end
   end

   assign stage_out = stage_ff;

endmodule
`default_nettype wire

// File: hdl/cheb_out.sv
// Output register: rounding, saturation and error zeroing of the three sums.
`timescale 1ns / 1ps
`default_nettype none
module cheb_out (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire cheb_pkg::stage_type  stage_in,
   output logic                  ready,
   output logic                  rsp_tvalid,
   input  wire logic             rsp_tready,
   output logic [3*cheb_pkg::OUT_W-1:0] rsp_tdata,
   output logic                  rsp_tuser
);

   localparam int HEAD_W = cheb_pkg::ACC_W - cheb_pkg::OUT_W + 1;

   cheb_pkg::acc_type r_val, r_d1, r_d2;
   cheb_pkg::out_type s_val, s_d1, s_d2;
   logic                                 valid_ff;
   logic [3*cheb_pkg::OUT_W-1:0]         data_ff, data_in;
   logic                                 err_ff;

   function automatic cheb_pkg::acc_type round_q(input cheb_pkg::acc_type a);
      cheb_pkg::acc_type biased;
      biased  = a + cheb_pkg::ACC_W'(cheb_pkg::ROUND_BIAS);
      round_q = biased >>> cheb_pkg::FRAC_SHIFT;
   endfunction

   function automatic cheb_pkg::out_type sat_q(input cheb_pkg::acc_type a);
      logic [HEAD_W-1:0] head;
      head = a[cheb_pkg::ACC_W-1 -: HEAD_W];
      priority if ((head == '0) || (head == '1)) begin
         sat_q = cheb_pkg::out_type'(a[cheb_pkg::OUT_W-1:0]);
      end else if (a[cheb_pkg::ACC_W-1]) begin
         sat_q = {1'b1, {(cheb_pkg::OUT_W-1){1'b0}}};
      end else begin
         sat_q = {1'b0, {(cheb_pkg::OUT_W-1){1'b1}}};
      end
   endfunction

   always_comb begin
      r_val = round_q(stage_in.val);
      r_d1  = round_q(stage_in.d1);
      r_d2  = round_q(stage_in.d2);
      s_val = sat_q(r_val);
      s_d1  = sat_q(r_d1);
      s_d2  = sat_q(r_d2);
      if (stage_in.err) begin
         data_in = '0;
      end else begin
         data_in = {s_d2, s_d1, s_val};
      end
   end

   assign ready = !valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ready) begin
         valid_ff <= stage_in.valid;
         data_ff  <= data_in;
         err_ff   <= stage_in.err;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tuser  = err_ff;

endmodule
`default_nettype wire

// File: tb/tb.sv
// Self-checking testbench for the Chebyshev series evaluator with first and second derivatives.
`timescale 1ns / 1ps
module tb;

   // Limits of the 48-bit signed result fields.
   localparam longint OUT_HI = (64'sd1 <<< (cheb_pkg::OUT_W - 1)) - 1;
   localparam longint OUT_LO = -(64'sd1 <<< (cheb_pkg::OUT_W - 1));

   // One result as the block should present it.
   typedef struct {
      cheb_pkg::out_type value;
      cheb_pkg::out_type slope;
      cheb_pkg::out_type curvature;
      logic              range_err;
   } series_result_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [15:0]  req_tdata = '0;      // [15:0] x_point
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [143:0] rsp_tdata;           // [47:0] series_value, [95:48] first_derivative,
                                      // [143:96] second_derivative
   logic         rsp_tuser;           // [0] range_error
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic [7:0]   csr_index = '0;
   logic [23:0]  csr_data = '0;

   chebyshev_series_eval_derivs dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // The testbench's own copy of the coefficient registers. It changes only while
   // the block is idle, so every item is predicted with the set it is evaluated with.
   cheb_pkg::coef_type coef_shadow [cheb_pkg::NUM_COEF];
   logic [15:0]        points_to_send [$];
   series_result_type  predicted_results [$];
   logic           x_on_bus = 1'b0;   // an item has left the queue but is not yet accepted
   int             pace_mode = 0;     // 0 means neither side idles
   int             burst_left = 0;
   int             gap_left = 0;
   int             stall_left = 0;
   int             rx_cycle = 0;
   int             error_count = 0;
   int             points_accepted = 0;
   int             points_outside = 0;
   int             results_checked = 0;
   int             settings_used = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   // Fixed-point helpers. The right shift of a signed longint is a floor, which
   // together with the half bias gives round half up.
   function automatic longint round_q14(input longint v);
      return (v + cheb_pkg::ROUND_BIAS) >>> cheb_pkg::FRAC_SHIFT;
   endfunction

   function automatic cheb_pkg::out_type sat48(input longint v);
      if (v > OUT_HI)
         v = OUT_HI;
      if (v < OUT_LO)
         v = OUT_LO;
      return v[cheb_pkg::OUT_W-1:0];
   endfunction

   // Evaluates f, f' and f'' at one point from the shadow coefficients.
   function automatic series_result_type eval_series(input logic [15:0] raw);
      series_result_type r;
      longint xv, acc_val, acc_d1, acc_d2, inner;
      longint tn [cheb_pkg::NUM_COEF];
      int n, k;
      r = '{value: '0, slope: '0, curvature: '0, range_err: 1'b0};
      xv = cheb_pkg::x_type'(raw);
      // A point outside [-1,1] only raises the flag; the values stay zero.
      if (xv < -cheb_pkg::ONE_Q14 || xv > cheb_pkg::ONE_Q14) begin
         r.range_err = 1'b1;
         return r;
      end
      // T_n by the three-term recurrence, each step rounded to Q14 and clamped to [-1,1].
      tn[0] = cheb_pkg::ONE_Q14;
      tn[1] = xv;
      for (n = 2; n < cheb_pkg::NUM_COEF; n++) begin
         tn[n] = round_q14(2 * xv * tn[n-1]) - tn[n-2];
         if (tn[n] > cheb_pkg::ONE_Q14)
            tn[n] = cheb_pkg::ONE_Q14;
         else if (tn[n] < -cheb_pkg::ONE_Q14)
            tn[n] = -cheb_pkg::ONE_Q14;
      end
      // All three sums are kept exact with 30 fraction bits until the final rounding.
      acc_val = 0;
      acc_d1  = 0;
      acc_d2  = 0;
      for (n = 0; n <= cheb_pkg::MAX_ORDER; n++)
         acc_val += longint'(coef_shadow[n]) * tn[n];
      for (k = 1; k <= cheb_pkg::MAX_ORDER; k += 2)
         acc_d1 += k * longint'(coef_shadow[k]) * cheb_pkg::ONE_Q14;
      for (n = 1; n <= cheb_pkg::MAX_ORDER; n++) begin
         inner = 0;
         for (k = n + 1; k <= cheb_pkg::MAX_ORDER; k += 2)
            inner += k * longint'(coef_shadow[k]);
         acc_d1 += 2 * inner * tn[n];
      end
      for (k = 2; k <= cheb_pkg::MAX_ORDER; k += 2)
         acc_d2 += (k * k * k / 2) * longint'(coef_shadow[k]) * cheb_pkg::ONE_Q14;
      for (n = 1; n <= cheb_pkg::MAX_ORDER; n++) begin
         inner = 0;
         for (k = n + 2; k <= cheb_pkg::MAX_ORDER; k += 2)
            inner += (k * (k * k - n * n)) * longint'(coef_shadow[k]);
         acc_d2 += inner * tn[n];
      end
      r.value     = sat48(round_q14(acc_val));
      r.slope     = sat48(round_q14(acc_d1));
      r.curvature = sat48(round_q14(acc_d2));
      return r;
   endfunction

   // Mostly points inside [-1,1], some at its edges and a few anywhere in the 16-bit range.
   function automatic logic [15:0] random_point();
      case ($urandom_range(0, 9))
         0: return 16'($urandom);
         1: return 16'(cheb_pkg::ONE_Q14 - 2 + $urandom_range(0, 4));
         2: return 16'(-cheb_pkg::ONE_Q14 - 2 + $urandom_range(0, 4));
         default: return 16'($urandom_range(0, 2 * cheb_pkg::ONE_Q14))
                         - 16'(cheb_pkg::ONE_Q14);
      endcase
   endfunction

   function automatic logic [23:0] random_coef();
      case ($urandom_range(0, 5))
         0: return 24'h7FFFFF;
         1: return 24'h800000;
         2: return 24'h000000;
         3: return 24'($urandom_range(0, 262143)) - 24'd131072;
         default: return 24'($urandom);
      endcase
   endfunction

   task automatic compare_field(input string label, input cheb_pkg::out_type want,
                                input cheb_pkg::out_type got);
      if (want !== got) begin
         error_count++;
         $display("%0t ns: %s expected %0d got %0d", $time, label, want, got);
      end
   endtask

   // Leaves csr_valid high on return, so back-to-back writes follow without a gap.
   // The caller lowers it after the last write of a group.
   task automatic write_coef(input logic [7:0] reg_index, input logic [23:0] word);
      csr_index <= reg_index;
      csr_data  <= word;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      // Writes to indexes above the last coefficient are dropped by the block.
      if (reg_index < cheb_pkg::NUM_COEF)
         coef_shadow[reg_index] = cheb_pkg::coef_type'(word);
   endtask

   // Returns once every queued point has been accepted and every result has come back.
   task automatic wait_drained();
      @(posedge clock);
      while (points_to_send.size() != 0 || x_on_bus || predicted_results.size() != 0)
         @(posedge clock);
   endtask

   // Sender: bursts of random length separated by random gaps, or an unbroken stream
   // in pace mode 0. A presented item is held until it is accepted. The expectation
   // is formed at the accepting edge from the point then on the bus.
   always @(posedge clock) begin
      logic present;
      int   gap_max;
      gap_max = (pace_mode == 0) ? 0 : (pace_mode == 2) ? 3 : 8;
      if (reset) begin
         req_tvalid <= 1'b0;
         burst_left = 0;
         gap_left   = 0;
      end else begin
         present = req_tvalid && !req_tready;
         if (req_tvalid && req_tready) begin
            predicted_results.push_back(eval_series(req_tdata));
            if (predicted_results[$].range_err)
               points_outside++;
            points_accepted++;
            x_on_bus = 1'b0;
         end
         if (!present) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (points_to_send.size() > 0) begin
               req_tdata <= points_to_send.pop_front();
               x_on_bus = 1'b1;
               present  = 1'b1;
               if (burst_left > 0) begin
                  burst_left--;
               end else if (gap_max > 0) begin
                  burst_left = $urandom_range(0, 15);
                  gap_left   = $urandom_range(1, gap_max);
               end
            end
         end
         req_tvalid <= present;
      end
   end

   // Receiver: checks each accepted result against the oldest prediction, then
   // chooses tready for the next edge. The stall patterns are always ready, random
   // three in four, a fixed repeating pattern, and rare long stalls that fill
   // the pipeline.
   always @(posedge clock) begin
      series_result_type want;
      logic ready_next;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (predicted_results.size() == 0) begin
            error_count++;
            $display("%0t ns: result with no item outstanding, expected none got %h", $time,
                     rsp_tdata);
         end else begin
            want = predicted_results.pop_front();
            compare_field("series_value", want.value,
                          cheb_pkg::out_type'(rsp_tdata[47:0]));
            compare_field("first_derivative", want.slope,
                          cheb_pkg::out_type'(rsp_tdata[95:48]));
            compare_field("second_derivative", want.curvature,
                          cheb_pkg::out_type'(rsp_tdata[143:96]));
            compare_field("range_error", cheb_pkg::out_type'(want.range_err),
                          cheb_pkg::out_type'(rsp_tuser));
            results_checked++;
         end
      end
      rx_cycle++;
      case (pace_mode)
         0: ready_next = 1'b1;
         1: ready_next = ($urandom_range(0, 3) != 0);
         2: ready_next = (rx_cycle % 11) >= 4;
         default: begin
            if (stall_left > 0) begin
               stall_left--;
               ready_next = 1'b0;
            end else if ($urandom_range(0, 19) == 0) begin
               stall_left = $urandom_range(5, 25);
               ready_next = 1'b0;
            end else begin
               ready_next = 1'b1;
            end
         end
      endcase
      rsp_tready <= reset ? 1'b0 : ready_next;
   end

   initial begin
      int p, i, k;
      logic [23:0] trial_coef [cheb_pkg::NUM_COEF];
      for (k = 0; k < cheb_pkg::NUM_COEF; k++)
         coef_shadow[k] = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // With the coefficients still at their reset value every result must be zero.
      settings_used++;
      pace_mode = 0;
      points_to_send = '{16'h4000, 16'hC000, 16'h4001};
      wait_drained();

      // Directed points against a fixed set with every coefficient nonzero, the two
      // extremes among them. The ends of [-1,1], the values just past them, the
      // extremes of the 16-bit field and alternating bit patterns are all included.
      trial_coef = '{24'h010000, 24'hFE0000, 24'h018000, 24'h7FFFFF,
                     24'h800000, 24'h009C40, 24'hFED02F, 24'h01E240};
      for (k = 0; k < cheb_pkg::NUM_COEF; k++)
         write_coef(8'(k), trial_coef[k]);
      // Out-of-range indexes must leave the coefficients alone.
      write_coef(8'hFF, 24'hFFFFFF);
      write_coef(8'h08, 24'h555555);
      csr_valid <= 1'b0;
      settings_used++;
      pace_mode = 1;
      points_to_send = '{16'h0000, 16'h4000, 16'hC000, 16'h0001, 16'hFFFF, 16'h2000,
                         16'hE000, 16'h2D41, 16'h3FFF, 16'hC001, 16'h4001, 16'hBFFF,
                         16'h7FFF, 16'h8000, 16'h5555, 16'hAAAA};
      wait_drained();

      // Random phases. The first three use all coefficients at the positive
      // extreme, all at the negative extreme, and alternating extremes; the rest
      // mix random, small, zero and extreme values. Pacing rotates with the phase.
      for (p = 0; p < 10; p++) begin
         for (k = 0; k < cheb_pkg::NUM_COEF; k++) begin
            if (p == 0)
               write_coef(8'(k), 24'h7FFFFF);
            else if (p == 1)
               write_coef(8'(k), 24'h800000);
            else if (p == 2)
               write_coef(8'(k), (k % 2 == 0) ? 24'h7FFFFF : 24'h800000);
            else
               write_coef(8'(k), random_coef());
         end
         write_coef(8'($urandom_range(cheb_pkg::NUM_COEF, 255)), 24'($urandom));
         csr_valid <= 1'b0;
         settings_used++;
         pace_mode = p % 4;
         for (i = 0; i < 100; i++)
            points_to_send.push_back(random_point());
         wait_drained();
      end

      // Give any stray result time to show up.
      repeat (20) @(posedge clock);
      $display("Evaluated %0d points (%0d outside [-1,1]) under %0d coefficient settings,",
               points_accepted, points_outside, settings_used);
      $display("checking %0d results with four sender and receiver pacing patterns.",
               results_checked);
      if (error_count == 0)
         $display("tb OK");
      else
         $display("tb NOT OK");
      $finish;
   end

   // Stops a run that does not finish in time.
   initial begin
      #2000000;
      $display("tb NOT OK");
      $finish;
   end

endmodule
